/* src/psg_tone_noise_envelope_assert.svh */
// Assertion macros used by the checker file.
`ifndef PSG_TONE_NOISE_ENVELOPE_ASSERT_SVH
`define PSG_TONE_NOISE_ENVELOPE_ASSERT_SVH

// Implication checked while out of reset.
`define PSG_ASSERT_RUN(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// Next-cycle implication checked at every edge, reset included.
`define PSG_ASSERT_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

/* src/psg_tne_pkg.sv */
package psg_tne_pkg;

    localparam int PRESCALE      = 16;
    localparam int DAC_FRAC_BITS = 12;
    localparam int PRESC_W       = (PRESCALE > 1) ? $clog2(PRESCALE) : 1;
    localparam int DAC_SHIFT     = 24 - DAC_FRAC_BITS;
    localparam int MIX_W         = 18;

    typedef enum logic [1:0] {
        MODE_SELECT = 2'd0,
        MODE_WRITE  = 2'd1,
        MODE_TICK   = 2'd2
    } t_mode;

    typedef enum logic [3:0] {
        REG_TONE_A_LO = 4'd0,
        REG_TONE_A_HI = 4'd1,
        REG_TONE_B_LO = 4'd2,
        REG_TONE_B_HI = 4'd3,
        REG_TONE_C_LO = 4'd4,
        REG_TONE_C_HI = 4'd5,
        REG_NOISE     = 4'd6,
        REG_MIXER     = 4'd7,
        REG_VOL_A     = 4'd8,
        REG_VOL_B     = 4'd9,
        REG_VOL_C     = 4'd10,
        REG_ENV_LO    = 4'd11,
        REG_ENV_HI    = 4'd12,
        REG_ENV_SHAPE = 4'd13,
        REG_SPARE_0   = 4'd14,
        REG_SPARE_1   = 4'd15
    } t_reg;

    // Envelope shape bits
    localparam int SHAPE_HOLD      = 0;
    localparam int SHAPE_ALTERNATE = 1;
    localparam int SHAPE_ATTACK    = 2;
    localparam int SHAPE_CONTINUE  = 3;

    typedef struct packed {
        logic [2:0]      tone_out;
        logic [5:0]      enables;     // 1 = source enabled
        logic [2:0][3:0] volume;
        logic [2:0]      use_env;
        logic            noise_bit;
        logic [4:0]      env_level;
    } t_mix_in;

    // DAC curve in Q24: 15 * 2^((l-31)/4), with level 0 mapped to 0
    localparam logic [27:0] DAC_Q24 [32] = '{
        28'd0,         28'd1390229,   28'd1653270,   28'd1966080,
        28'd2338076,   28'd2780457,   28'd3306539,   28'd3932160,
        28'd4676153,   28'd5560914,   28'd6613079,   28'd7864320,
        28'd9352305,   28'd11121828,  28'd13226157,  28'd15728640,
        28'd18704611,  28'd22243656,  28'd26452314,  28'd31457280,
        28'd37409221,  28'd44487312,  28'd52904628,  28'd62914560,
        28'd74818442,  28'd88974624,  28'd105809256, 28'd125829120,
        28'd149636885, 28'd177949248, 28'd211618512, 28'd251658240
    };

    function automatic logic [MIX_W-1:0] dac_value(input logic [4:0] level);
        logic [28:0] rounded;
        rounded = {1'b0, DAC_Q24[level]} + (29'd1 << (DAC_SHIFT - 1));
        dac_value = MIX_W'(rounded >> DAC_SHIFT);
    endfunction

endpackage

/* src/psg_tne_mix.sv */
module psg_tne_mix
    import psg_tne_pkg::*;
(
    input  t_mix_in          i_mix,
    output logic [MIX_W-1:0] o_level
);

    logic [2:0][MIX_W-1:0] chan_val;

    always_comb begin
        logic [4:0] lvl;
        logic       mute;
        for (int ch = 0; ch < 3; ch++) begin
            // disabled source counts as high
            mute = (i_mix.enables[ch] && !i_mix.tone_out[ch]) ||
                   (i_mix.enables[ch + 3] && !i_mix.noise_bit);
            if (i_mix.use_env[ch]) begin
                lvl = i_mix.env_level;
            end else if (i_mix.volume[ch] == 4'd0) begin
                lvl = 5'd0;
            end else begin
                lvl = {i_mix.volume[ch], 1'b1};
            end
            chan_val[ch] = mute ? '0 : dac_value(lvl);
        end
    end

    assign o_level = chan_val[0] + chan_val[1] + chan_val[2];

endmodule

/* src/psg_tone_noise_envelope.sv */
// Three-channel tone, noise and envelope sound generator.
// Input channel (i_in_valid / o_in_ready): i_mode selects the action,
// i_data carries a register number (select), a data byte (write) or is
// ignored (one clock tick). Mode 3 changes nothing.
// Output channel (o_out_valid / i_out_ready): one o_mix_level per input
// transaction, in order, unsigned with 12 fraction bits.
// Between an input transaction and its result lie the input register, the state
// update and the result register. Throughput: one transaction per cycle unless the receiver stalls.
// The three stages advance together whenever the result register is empty
// or being taken, so a stalled receiver holds the whole pipeline and
// o_in_ready follows i_out_ready combinationally.
// The prescaler divides ticks by 16 before clocking tone, noise and envelope.
// Reset (i_rst_n low, synchronous) clears all sound state, empties the
// pipeline and loads the noise shifter with 1; no clearing pass is needed.
module psg_tone_noise_envelope
    import psg_tne_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [1:0]       i_mode,
    input  logic [7:0]       i_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [MIX_W-1:0] o_mix_level
);

    logic             en;
    logic             r_in_valid, r_st_valid, r_out_valid;
    logic [1:0]       r_in_mode;
    logic [7:0]       r_in_data;
    logic [MIX_W-1:0] r_out_level;

    logic [3:0]       r_sel,        n_sel;
    logic [11:0]      r_tone_per [3], n_tone_per [3];
    logic [11:0]      r_tone_tmr [3], n_tone_tmr [3];
    logic [2:0]       r_tone_out,   n_tone_out;
    logic [5:0]       r_enables,    n_enables;
    logic [3:0]       r_volume [3], n_volume [3];
    logic [2:0]       r_use_env,    n_use_env;
    logic [4:0]       r_noise_per,  n_noise_per;
    logic [5:0]       r_noise_tmr,  n_noise_tmr;
    logic [16:0]      r_noise_sh,   n_noise_sh;
    logic [15:0]      r_env_per,    n_env_per;
    logic [15:0]      r_env_tmr,    n_env_tmr;
    logic [3:0]       r_env_shape,  n_env_shape;
    logic [4:0]       r_env_step,   n_env_step;
    logic [4:0]       r_env_level,  n_env_level;
    logic             r_env_rising, n_env_rising;
    logic             r_env_held,   n_env_held;
    logic [PRESC_W-1:0] r_presc,    n_presc;

    t_mix_in          mix_in;
    logic [MIX_W-1:0] mix_level;

    assign en          = !r_out_valid || i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_out_valid;
    assign o_mix_level = r_out_level;

    always_comb begin
        logic [11:0] per;
        logic [1:0]  ch;
        n_sel        = r_sel;
        n_tone_per   = r_tone_per;
        n_tone_tmr   = r_tone_tmr;
        n_tone_out   = r_tone_out;
        n_enables    = r_enables;
        n_volume     = r_volume;
        n_use_env    = r_use_env;
        n_noise_per  = r_noise_per;
        n_noise_tmr  = r_noise_tmr;
        n_noise_sh   = r_noise_sh;
        n_env_per    = r_env_per;
        n_env_tmr    = r_env_tmr;
        n_env_shape  = r_env_shape;
        n_env_step   = r_env_step;
        n_env_level  = r_env_level;
        n_env_rising = r_env_rising;
        n_env_held   = r_env_held;
        n_presc      = r_presc;
        per          = '0;
        ch           = r_sel[2:1];

        case (t_mode'(r_in_mode))
            MODE_SELECT: begin
                n_sel = r_in_data[3:0];
            end
            MODE_WRITE: begin
                case (t_reg'(r_sel))
                    REG_TONE_A_LO, REG_TONE_B_LO, REG_TONE_C_LO: begin
                        n_tone_per[ch] = {r_tone_per[ch][11:8], r_in_data};
                    end
                    REG_TONE_A_HI, REG_TONE_B_HI, REG_TONE_C_HI: begin
                        n_tone_per[ch] = {r_in_data[3:0], r_tone_per[ch][7:0]};
                    end
                    REG_NOISE: n_noise_per = r_in_data[4:0];
                    REG_MIXER: n_enables   = ~r_in_data[5:0];
                    REG_VOL_A: begin
                        n_volume[0]  = r_in_data[3:0];
                        n_use_env[0] = r_in_data[4];
                    end
                    REG_VOL_B: begin
                        n_volume[1]  = r_in_data[3:0];
                        n_use_env[1] = r_in_data[4];
                    end
                    REG_VOL_C: begin
                        n_volume[2]  = r_in_data[3:0];
                        n_use_env[2] = r_in_data[4];
                    end
                    REG_ENV_LO: n_env_per = {r_env_per[15:8], r_in_data};
                    REG_ENV_HI: n_env_per = {r_in_data, r_env_per[7:0]};
                    REG_ENV_SHAPE: begin
                        // restart the envelope
                        n_env_shape  = r_in_data[3:0];
                        n_env_step   = '0;
                        n_env_rising = r_in_data[SHAPE_ATTACK];
                        n_env_held   = 1'b0;
                        n_env_level  = r_in_data[SHAPE_ATTACK] ? 5'd0 : 5'd31;
                        n_env_tmr    = r_env_per;
                    end
                    default: ;
                endcase
            end
            MODE_TICK: begin
                if (r_presc != PRESC_W'(PRESCALE - 1)) begin
                    n_presc = r_presc + 1'b1;
                end else begin
                    n_presc = '0;
                    for (int c = 0; c < 3; c++) begin
                        if (r_tone_tmr[c] == 12'd0) begin
                            per           = (r_tone_per[c] == 12'd0) ? 12'd1 : r_tone_per[c];
                            n_tone_tmr[c] = per - 12'd1;
                            n_tone_out[c] = !r_tone_out[c];
                        end else begin
                            n_tone_tmr[c] = r_tone_tmr[c] - 12'd1;
                        end
                    end

                    if (r_noise_tmr == 6'd0) begin
                        n_noise_tmr = {r_noise_per, 1'b1};
                        n_noise_sh  = {r_noise_sh[0] ^ r_noise_sh[3], r_noise_sh[16:1]};
                    end else begin
                        n_noise_tmr = r_noise_tmr - 6'd1;
                    end

                    if (r_env_tmr != 16'd0) begin
                        n_env_tmr = r_env_tmr - 16'd1;
                    end else begin
                        n_env_tmr = r_env_per;
                        if (!r_env_held) begin
                            if (r_env_step != 5'd31) begin
                                n_env_step  = r_env_step + 5'd1;
                                n_env_level = r_env_rising ? n_env_step : ~n_env_step;
                            end else if (!r_env_shape[SHAPE_CONTINUE]) begin
                                n_env_held  = 1'b1;
                                n_env_level = 5'd0;
                            end else if (r_env_shape[SHAPE_HOLD]) begin
                                // hold at the end level, flipped by alternate
                                n_env_held  = 1'b1;
                                n_env_level = (r_env_shape[SHAPE_ALTERNATE] ^ r_env_rising)
                                              ? 5'd31 : 5'd0;
                            end else begin
                                n_env_rising = r_env_rising ^ r_env_shape[SHAPE_ALTERNATE];
                                n_env_step   = 5'd0;
                                n_env_level  = n_env_rising ? 5'd0 : 5'd31;
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_st_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_sel        <= '0;
            r_tone_out   <= '0;
            r_enables    <= '0;
            r_use_env    <= '0;
            r_noise_per  <= '0;
            r_noise_tmr  <= '0;
            r_noise_sh   <= 17'd1;
            r_env_per    <= '0;
            r_env_tmr    <= '0;
            r_env_shape  <= '0;
            r_env_step   <= '0;
            r_env_level  <= '0;
            r_env_rising <= 1'b0;
            r_env_held   <= 1'b0;
            r_presc      <= '0;
            for (int c = 0; c < 3; c++) begin
                r_tone_per[c] <= '0;
                r_tone_tmr[c] <= '0;
                r_volume[c]   <= '0;
            end
        end else if (en) begin
            r_in_valid  <= i_in_valid;
            r_st_valid  <= r_in_valid;
            r_out_valid <= r_st_valid;
            if (r_in_valid) begin
                r_sel        <= n_sel;
                r_tone_per   <= n_tone_per;
                r_tone_tmr   <= n_tone_tmr;
                r_tone_out   <= n_tone_out;
                r_enables    <= n_enables;
                r_volume     <= n_volume;
                r_use_env    <= n_use_env;
                r_noise_per  <= n_noise_per;
                r_noise_tmr  <= n_noise_tmr;
                r_noise_sh   <= n_noise_sh;
                r_env_per    <= n_env_per;
                r_env_tmr    <= n_env_tmr;
                r_env_shape  <= n_env_shape;
                r_env_step   <= n_env_step;
                r_env_level  <= n_env_level;
                r_env_rising <= n_env_rising;
                r_env_held   <= n_env_held;
                r_presc      <= n_presc;
            end
        end
    end

    // payload registers: no reset
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in_mode   <= i_mode;
            r_in_data   <= i_data;
            r_out_level <= mix_level;
        end
    end

    always_comb begin
        mix_in.tone_out  = r_tone_out;
        mix_in.enables   = r_enables;
        mix_in.use_env   = r_use_env;
        mix_in.noise_bit = r_noise_sh[0];
        mix_in.env_level = r_env_level;
        for (int c = 0; c < 3; c++) begin
            mix_in.volume[c] = r_volume[c];
        end
    end

    psg_tne_mix u_mix (
        .i_mix   (mix_in),
        .o_level (mix_level)
    );

endmodule

/* src/psg_tne_checker.sv */
`include "psg_tone_noise_envelope_assert.svh"

module psg_tne_checker
    import psg_tne_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_in_ready,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input logic [MIX_W-1:0] o_mix_level
);

    // a stalled result holds
    `PSG_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n && o_out_valid && !i_out_ready, o_out_valid && $stable(o_mix_level))

    // reset empties the result register
    `PSG_ASSERT_NEXT(a_reset_empty, i_clk, !i_rst_n, !o_out_valid)

    // three channels at full scale at most
    `PSG_ASSERT_RUN(a_mix_range, i_clk, i_rst_n, o_out_valid, o_mix_level <= 18'd184320)

    // an empty result register never blocks the input
    `PSG_ASSERT_RUN(a_ready_when_empty, i_clk, i_rst_n, !o_out_valid, o_in_ready)

endmodule

bind psg_tone_noise_envelope psg_tne_checker u_chk (.*);
